FILE: rtl/bedf_pkg.sv
// Package for the bounded event FIFO with drop statistics.
// Holds the sizing constants and the result status codes; no dependencies.
`default_nettype none
package bedf_pkg;

  localparam int QUEUE_DEPTH = 64;
  localparam int EVENT_WIDTH = 64;
  localparam int ADDR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int STAT_W      = 32;

  typedef enum logic [1:0] {
    OP_PUSH    = 2'd0,
    OP_POP     = 2'd1,
    OP_CLOSE   = 2'd2,
    OP_DISCARD = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_PUSHED     = 3'd0,
    ST_DROPPED    = 3'd1,
    ST_REFUSED    = 3'd2,
    ST_FULL_WAIT  = 3'd3,
    ST_POPPED     = 3'd4,
    ST_EMPTY_WAIT = 3'd5,
    ST_FINISHED   = 3'd6,
    ST_CONTROL    = 3'd7
  } status_e;

  typedef enum logic {
    REG_FULL_POLICY = 1'b0,
    REG_CAPACITY    = 1'b1
  } cfg_reg_e;

endpackage
`default_nettype wire

FILE: rtl/bedf_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Self-contained; used for the event slot store.
`default_nettype none
module bedf_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  wire logic                                      clk_i,
  input  wire logic                                      we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                          wdata_i,
  input  wire logic                                      re_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                          rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

FILE: rtl/bounded_event_fifo_with_drop_stats_core.sv
// Bounded ring FIFO of event words with drop policy and saturating statistics.
// Each accepted beat's result is registered and shown in the cycle after.
// One beat per cycle unless a held result stalls; pushes write, pops read RAM.
// The result register holds status while depth and counters come from the state.
// Reset clears pointers, counters and flags; the slot RAM is not cleared.
// Depends on bedf_pkg and bedf_ram.
`default_nettype none
module bounded_event_fifo_with_drop_stats_core (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic                            cfg_index_i,
  input  wire logic [bedf_pkg::CNT_W-1:0]      cfg_wdata_i,
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire logic [1:0]                      op_i,
  input  wire logic [bedf_pkg::EVENT_WIDTH-1:0] event_data_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output logic [2:0]                           status_o,
  output logic [bedf_pkg::EVENT_WIDTH-1:0]     data_out_o,
  output logic [bedf_pkg::CNT_W-1:0]           current_depth_o,
  output logic [bedf_pkg::CNT_W-1:0]           peak_depth_o,
  output logic [bedf_pkg::STAT_W-1:0]          dropped_total_o,
  output logic [bedf_pkg::STAT_W-1:0]          failed_total_o
);
  import bedf_pkg::*;

  logic                   policy_q;
  logic [CNT_W-1:0]       cap_q;
  logic [ADDR_W-1:0]      wr_idx_q, wr_idx_d;
  logic [ADDR_W-1:0]      rd_idx_q, rd_idx_d;
  logic [CNT_W-1:0]       fill_q, fill_d;
  logic [CNT_W-1:0]       peak_q, peak_d;
  logic [STAT_W-1:0]      drop_q, drop_d;
  logic [STAT_W-1:0]      fail_q, fail_d;
  logic                   closed_q, closed_d;
  logic                   discard_q, discard_d;
  status_e                status_q, status_d;
  logic                   out_valid_q;

  logic                   accept;
  logic [CNT_W-1:0]       cap_eff;
  logic [CNT_W-1:0]       wr_inc, rd_inc;
  logic                   ram_we, ram_re;
  logic [EVENT_WIDTH-1:0] ram_rdata;
  logic [STAT_W-1:0]      drop_inc, fail_inc;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    if (cap_q == '0) begin
      cap_eff = CNT_W'(1);
    end else if (cap_q > CNT_W'(QUEUE_DEPTH)) begin
      cap_eff = CNT_W'(QUEUE_DEPTH);
    end else begin
      cap_eff = cap_q;
    end
  end

  assign wr_inc   = CNT_W'(wr_idx_q) + CNT_W'(1);
  assign rd_inc   = CNT_W'(rd_idx_q) + CNT_W'(1);
  assign drop_inc = (drop_q == '1) ? drop_q : drop_q + STAT_W'(1);
  assign fail_inc = (fail_q == '1) ? fail_q : fail_q + STAT_W'(1);

  always_comb begin
    wr_idx_d  = wr_idx_q;
    rd_idx_d  = rd_idx_q;
    fill_d    = fill_q;
    peak_d    = peak_q;
    drop_d    = drop_q;
    fail_d    = fail_q;
    closed_d  = closed_q;
    discard_d = discard_q;
    status_d  = ST_CONTROL;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    case (op_e'(op_i))
      OP_PUSH: begin
        if (closed_q) begin
          status_d = ST_REFUSED;
          if (!policy_q) begin
            drop_d = drop_inc;
          end
          fail_d = fail_inc;
        end else if (fill_q >= cap_eff) begin
          if (!policy_q) begin
            status_d = ST_DROPPED;
            drop_d   = drop_inc;
            fail_d   = fail_inc;
          end else begin
            status_d = ST_FULL_WAIT;
          end
        end else begin
          status_d = ST_PUSHED;
          ram_we   = 1'b1;
          wr_idx_d = (wr_inc >= cap_eff) ? '0 : wr_inc[ADDR_W-1:0];
          fill_d   = fill_q + CNT_W'(1);
          if (fill_d > peak_q) begin
            peak_d = fill_d;
          end
        end
      end
      OP_POP: begin
        if (discard_q) begin
          status_d = ST_FINISHED;
        end else if (fill_q != '0) begin
          status_d = ST_POPPED;
          ram_re   = 1'b1;
          rd_idx_d = (rd_inc >= cap_eff) ? '0 : rd_inc[ADDR_W-1:0];
          fill_d   = fill_q - CNT_W'(1);
        end else if (closed_q) begin
          status_d = ST_FINISHED;
        end else begin
          status_d = ST_EMPTY_WAIT;
        end
      end
      OP_CLOSE: begin
        closed_d = 1'b1;
      end
      OP_DISCARD: begin
        closed_d  = 1'b1;
        discard_d = 1'b1;
        fill_d    = '0;
      end
      default: begin
        status_d = ST_CONTROL;
      end
    endcase
  end

  bedf_ram #(
    .WIDTH(EVENT_WIDTH),
    .DEPTH(QUEUE_DEPTH)
  ) u_slot_ram (
    .clk_i  (clk_i),
    .we_i   (accept && ram_we),
    .waddr_i(wr_idx_q),
    .wdata_i(event_data_i),
    .re_i   (accept && ram_re),
    .raddr_i(rd_idx_q),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q    <= 1'b0;
      cap_q       <= CNT_W'(QUEUE_DEPTH);
      wr_idx_q    <= '0;
      rd_idx_q    <= '0;
      fill_q      <= '0;
      peak_q      <= '0;
      drop_q      <= '0;
      fail_q      <= '0;
      closed_q    <= 1'b0;
      discard_q   <= 1'b0;
      status_q    <= ST_CONTROL;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_index_i))
          REG_FULL_POLICY: policy_q <= cfg_wdata_i[0];
          REG_CAPACITY:    cap_q    <= cfg_wdata_i;
          default:         cap_q    <= cap_q;
        endcase
      end
      if (accept) begin
        wr_idx_q  <= wr_idx_d;
        rd_idx_q  <= rd_idx_d;
        fill_q    <= fill_d;
        peak_q    <= peak_d;
        drop_q    <= drop_d;
        fail_q    <= fail_d;
        closed_q  <= closed_d;
        discard_q <= discard_d;
        status_q  <= status_d;
      end
      if (in_ready_o) begin
        out_valid_q <= in_valid_i;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign data_out_o      = (status_q == ST_POPPED) ? ram_rdata : '0;
  assign current_depth_o = fill_q;
  assign peak_depth_o    = peak_q;
  assign dropped_total_o = drop_q;
  assign failed_total_o  = fail_q;

endmodule
`default_nettype wire
